@@ design/hrhe_pkg.sv @@
// ----------------------------------------------------------------------------
// hrhe_pkg
// Shared constants and codes for the heart rate harmonic estimator.
// ----------------------------------------------------------------------------
package hrhe_pkg;

	localparam int WINDOW_EVENTS = 30;
	localparam int TIME_W        = 32;
	localparam int N_IVAL        = WINDOW_EVENTS - 1;
	localparam int IDX_W         = $clog2(N_IVAL);
	localparam int CNT_W         = $clog2(N_IVAL + 2);
	localparam int FILL_W        = $clog2(WINDOW_EVENTS + 1);
	localparam int MID_LO        = (N_IVAL - 1) / 2;
	localparam int MID_HI        = N_IVAL / 2;
	localparam int SPAN_W        = TIME_W + $clog2(N_IVAL);
	localparam int BEATS_W       = $clog2(5 * N_IVAL + 1);
	localparam int DIST_W        = TIME_W + 5;
	localparam int N_CAND        = 6;

	localparam int TPS_W         = 20;
	localparam int TPS60_W       = TPS_W + 6;
	localparam int MUL_W         = TPS60_W + BEATS_W;
	localparam int NUM_W         = MUL_W + 8;
	localparam int DCNT_W        = $clog2(NUM_W + 1);
	localparam int RATE_W        = 16;

	localparam logic [TPS_W-1:0]  TPS_RESET = TPS_W'(1000);
	localparam logic [RATE_W-1:0] RATE_MAX  = '1;

	// APB register map
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;
	localparam logic [ADDR_W-3:0] REG_TPS = '0;

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_SCAN = 3'd2;
	localparam logic [2:0] ST_MID  = 3'd3;
	localparam logic [2:0] ST_MULT = 3'd4;
	localparam logic [2:0] ST_BEAT = 3'd5;
	localparam logic [2:0] ST_DIV  = 3'd6;
	localparam logic [2:0] ST_DONE = 3'd7;

	typedef logic [DIST_W-1:0] dist_t;

	function automatic dist_t absdiff(input dist_t a, input dist_t b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

@@ design/hrhe_ram.sv @@
// ----------------------------------------------------------------------------
// hrhe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hrhe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ design/heart_rate_harmonic_estimator_top.sv @@
// ----------------------------------------------------------------------------
// heart_rate_harmonic_estimator_top
// Median-referenced heart rate estimate over a sliding window of pulse events.
// ----------------------------------------------------------------------------
// One request at a time. The first 30 events only fill the window and are taken
// while in_ready stays high. Every later event yields one estimate. A rank-count
// median over the 29 stored intervals takes passes through the single read port
// of the interval RAM, one pass per pivot tried, 1 to 29 passes. Then come a
// median average state, a candidate setup state and a harmonic match pass. After
// that, a bit-serial divide, whose first step forms the 60 x ticks x beats
// product, and the load of the output register. in_ready is low meanwhile. The
// finished estimate sits in an output register, so the next event can be taken
// while it waits. Span zero divides to all ones and so saturates.
module heart_rate_harmonic_estimator_top
	import hrhe_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [31:0]       event_time,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [31:0]       result_time,
	output logic [15:0]       heart_rate,
	output logic              saturated
);

	logic [TPS_W-1:0]  tps_q;
	logic [2:0]        state_q;
	logic [FILL_W-1:0] fill_q;
	logic [TIME_W-1:0] last_q;
	logic [IDX_W-1:0]  wp_q;
	logic [31:0]       rtime_q;
	logic [IDX_W-1:0]  i_q;
	logic [CNT_W-1:0]  j_q;
	logic [TIME_W-1:0] pivot_q;
	logic [CNT_W-1:0]  lt_q, le_q;
	logic [SPAN_W-1:0] span_q;
	logic [TIME_W-1:0] med_lo_q, med_hi_q;
	logic              got_lo_q, got_hi_q;
	logic [TIME_W-1:0] m_q;
	dist_t             cand_q [N_CAND];
	logic              rd_vld_s1;
	dist_t             dist_s2 [N_CAND];
	logic              vld_s2;
	logic [BEATS_W-1:0] beats_q;
	logic [NUM_W-1:0]  num_q, quo_q;
	logic [SPAN_W-1:0] rem_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic              out_valid_q;
	logic [15:0]       rate_q;
	logic              sat_q;

	logic              in_acc;
	logic              ram_we;
	logic [IDX_W-1:0]  ram_raddr;
	logic [TIME_W-1:0] ram_rdata;
	logic [CNT_W-1:0]  lt_n, le_n;
	logic              lo_hit, hi_hit;
	dist_t             d2;
	logic [2:0]        beat_sel;
	dist_t             best;
	logic [SPAN_W:0]   rem_sh;
	logic              qbit;
	logic [TPS60_W-1:0] tps60;
	logic              out_load;

	// ---------------- configuration ----------------
	assign pready = 1'b1;
	assign prdata = (paddr[ADDR_W-1:2] == REG_TPS) ? DATA_W'(tps_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= TPS_RESET;
		end else if (psel && penable && pwrite && pready
				&& paddr[ADDR_W-1:2] == REG_TPS) begin
			tps_q <= pwdata[TPS_W-1:0];
		end
	end

	// ---------------- interval memory ----------------
	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign ram_we   = in_acc && (fill_q != '0);

	always_comb begin
		ram_raddr = '0;
		case (state_q)
			ST_LOAD: ram_raddr = i_q;
			ST_SCAN, ST_BEAT: begin
				if (j_q < CNT_W'(N_IVAL)) ram_raddr = j_q[IDX_W-1:0];
			end
			default: ram_raddr = '0;
		endcase
	end

	hrhe_ram #(
		.WIDTH(TIME_W),
		.DEPTH(N_IVAL)
	) u_ival_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wp_q),
		.wdata(event_time[TIME_W-1:0] - last_q),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// ---------------- datapath helpers ----------------
	assign lt_n   = lt_q + CNT_W'(ram_rdata < pivot_q);
	assign le_n   = le_q + CNT_W'(ram_rdata <= pivot_q);
	assign lo_hit = (lt_n <= CNT_W'(MID_LO)) && (CNT_W'(MID_LO) < le_n);
	assign hi_hit = (lt_n <= CNT_W'(MID_HI)) && (CNT_W'(MID_HI) < le_n);
	assign d2     = dist_t'({ram_rdata, 1'b0});

	// nearest candidate, first one wins on a tie; 0.5x counts one beat
	always_comb begin
		best     = dist_s2[0];
		beat_sel = 3'd1;
		for (int k = 1; k < 5; k++) begin
			if (dist_s2[k] < best) begin
				best     = dist_s2[k];
				beat_sel = 3'(k + 1);
			end
		end
		if (dist_s2[5] < best) beat_sel = 3'd1;
	end

	assign tps60  = (TPS60_W'(tps_q) << 6) - (TPS60_W'(tps_q) << 2);
	assign rem_sh = {rem_q, num_q[NUM_W-1]};
	assign qbit   = (rem_sh >= {1'b0, span_q});

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			wp_q        <= '0;
			i_q         <= '0;
			j_q         <= '0;
			got_lo_q    <= 1'b0;
			got_hi_q    <= 1'b0;
			rd_vld_s1   <= 1'b0;
			vld_s2      <= 1'b0;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_BEAT) && (j_q < CNT_W'(N_IVAL));
			vld_s2    <= rd_vld_s1;
			if (out_load || out_ready) out_valid_q <= out_load;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (fill_q != '0) begin
							wp_q <= (wp_q == IDX_W'(N_IVAL - 1)) ? '0 : wp_q + 1'b1;
						end
						if (fill_q < FILL_W'(WINDOW_EVENTS)) begin
							fill_q <= fill_q + 1'b1;
						end else begin
							state_q  <= ST_LOAD;
							i_q      <= '0;
							got_lo_q <= 1'b0;
							got_hi_q <= 1'b0;
						end
					end
				end
				ST_LOAD: begin
					state_q <= ST_SCAN;
					j_q     <= '0;
				end
				ST_SCAN: begin
					j_q <= j_q + 1'b1;
					if (j_q == CNT_W'(N_IVAL)) begin
						if (lo_hit) got_lo_q <= 1'b1;
						if (hi_hit) got_hi_q <= 1'b1;
						if ((got_lo_q || lo_hit) && (got_hi_q || hi_hit)) begin
							state_q <= ST_MID;
						end else begin
							state_q <= ST_LOAD;
							i_q     <= i_q + 1'b1;
						end
					end
				end
				ST_MID: state_q <= ST_MULT;
				ST_MULT: begin
					state_q <= ST_BEAT;
					j_q     <= '0;
				end
				ST_BEAT: begin
					j_q <= j_q + 1'b1;
					if (j_q == CNT_W'(N_IVAL + 1)) state_q <= ST_DIV;
					if (j_q == CNT_W'(N_IVAL + 1)) dcnt_q <= '0;
				end
				ST_DIV: begin
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == DCNT_W'(NUM_W)) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------- payload registers ----------------
	always_ff @(posedge clk) begin
		if (in_acc) begin
			last_q  <= event_time[TIME_W-1:0];
			rtime_q <= event_time;
			span_q  <= '0;
			beats_q <= '0;
		end
		if (state_q == ST_LOAD) begin
			lt_q <= '0;
			le_q <= '0;
		end
		if (state_q == ST_SCAN) begin
			if (j_q == '0) begin
				pivot_q <= ram_rdata;
			end else begin
				lt_q <= lt_n;
				le_q <= le_n;
				if (i_q == '0) span_q <= span_q + SPAN_W'(ram_rdata);
				if (j_q == CNT_W'(N_IVAL)) begin
					if (lo_hit) med_lo_q <= pivot_q;
					if (hi_hit) med_hi_q <= pivot_q;
				end
			end
		end
		if (state_q == ST_MID) begin
			m_q <= TIME_W'(({1'b0, med_lo_q} + {1'b0, med_hi_q}) >> 1);
		end
		if (state_q == ST_MULT) begin
			cand_q[0] <= dist_t'(m_q) << 1;
			cand_q[1] <= dist_t'(m_q) << 2;
			cand_q[2] <= (dist_t'(m_q) << 2) + (dist_t'(m_q) << 1);
			cand_q[3] <= dist_t'(m_q) << 3;
			cand_q[4] <= (dist_t'(m_q) << 3) + (dist_t'(m_q) << 1);
			cand_q[5] <= dist_t'(m_q);
		end
		if (rd_vld_s1) begin
			for (int k = 0; k < N_CAND; k++) begin
				dist_s2[k] <= absdiff(d2, cand_q[k]);
			end
		end
		if (vld_s2) beats_q <= beats_q + BEATS_W'(beat_sel);
		if (state_q == ST_BEAT && j_q == CNT_W'(N_IVAL + 1)) begin
			// last beat count lands this cycle; multiply next cycle in DIV setup
			num_q <= '0;
		end
		if (state_q == ST_DIV) begin
			if (dcnt_q == '0) begin
				num_q <= {MUL_W'(tps60 * beats_q), 8'b0};
				rem_q <= '0;
				quo_q <= '0;
			end else begin
				num_q <= num_q << 1;
				quo_q <= {quo_q[NUM_W-2:0], qbit};
				rem_q <= qbit ? SPAN_W'(rem_sh - {1'b0, span_q}) : rem_sh[SPAN_W-1:0];
			end
		end
		if (out_load) begin
			result_time <= rtime_q;
			if (quo_q > NUM_W'(RATE_MAX)) begin
				rate_q <= RATE_MAX;
				sat_q  <= 1'b1;
			end else begin
				rate_q <= quo_q[RATE_W-1:0];
				sat_q  <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign heart_rate = rate_q;
	assign saturated  = sat_q;

endmodule
